>>> rtl/pfi_pkg.sv
// Shared types, constants and fixed-point helpers for the particle force integrator.
package pfi_pkg;

    localparam int FORCE_SLOTS = 4;
    localparam int DIST_BIAS   = 655;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 48;
    localparam int LANE_LAT    = 3 + SQRT_STEPS + 1 + DIV_STEPS + 3;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GRAVITY,
        KIND_WIND,
        KIND_ATTRACTOR
    } kind_t;

    typedef struct packed {
        logic signed [31:0] strength;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [30:0] radius;
    } slot_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } dv_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] addv(input logic signed [31:0] v,
                                                input logic signed [32:0] d);
        logic signed [63:0] s;
        s = 64'(v) + 64'(d);
        return sat32(s);
    endfunction

    function automatic logic [31:0] absval(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

>>> rtl/pfi_lane.sv
// One force slot lane: velocity change of one slot for one particle, fully pipelined.
module pfi_lane (
    input  logic               clk,
    input  logic               en,
    input  pfi_pkg::kind_t     kind,
    input  pfi_pkg::slot_t     cfg,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic        [20:0] dt,
    output pfi_pkg::dv_t       dv
);

    typedef struct packed {
        pfi_pkg::kind_t     kind;
        logic signed [31:0] st;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] d_x;
        logic signed [31:0] d_y;
        logic signed [31:0] d_z;
        logic        [30:0] radius;
        logic        [20:0] dt;
    } carry_t;

    carry_t      c1_next, c1_reg, c2_reg, c3_reg;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;

    carry_t      sq_c_reg [pfi_pkg::SQRT_STEPS];
    logic [63:0] sq_n_reg [pfi_pkg::SQRT_STEPS];
    logic [63:0] sq_r_reg [pfi_pkg::SQRT_STEPS];

    carry_t                         ds_c_reg;
    logic [31:0]                    ds_dist_reg;
    logic                           ds_hit_reg, ds_neg_reg;
    logic [pfi_pkg::DIV_STEPS-1:0]  ds_qd_reg;
    logic [31:0]                    root;
    logic [32:0]                    dist_sum;
    logic [31:0]                    dist_next;

    carry_t                         dq_c_reg    [pfi_pkg::DIV_STEPS];
    logic [31:0]                    dq_dist_reg [pfi_pkg::DIV_STEPS];
    logic [31:0]                    dq_rem_reg  [pfi_pkg::DIV_STEPS];
    logic [pfi_pkg::DIV_STEPS-1:0]  dq_qd_reg   [pfi_pkg::DIV_STEPS];
    logic                           dq_hit_reg  [pfi_pkg::DIV_STEPS];
    logic                           dq_neg_reg  [pfi_pkg::DIV_STEPS];

    carry_t             sg_c_reg;
    logic               sg_hit_reg;
    logic signed [31:0] sg_s_reg;
    logic        [63:0] qq;
    logic signed [63:0] sv;

    pfi_pkg::kind_t     m_kind_reg;
    logic               m_hit_reg;
    logic        [20:0] m_dt_reg;
    logic signed [31:0] mx_reg, my_reg, mz_reg;
    logic signed [31:0] ax_op, ay_op, az_op, b_op, dt_s;

    pfi_pkg::dv_t       dv_next, dv_reg;

    always_comb
    begin
        c1_next.kind   = kind;
        c1_next.st     = cfg.strength;
        c1_next.dir_x  = cfg.dir_x;
        c1_next.dir_y  = cfg.dir_y;
        c1_next.dir_z  = cfg.dir_z;
        c1_next.d_x    = pfi_pkg::qsub(cfg.pos_x, pos_x);
        c1_next.d_y    = pfi_pkg::qsub(cfg.pos_y, pos_y);
        c1_next.d_z    = pfi_pkg::qsub(cfg.pos_z, pos_z);
        c1_next.radius = cfg.radius;
        c1_next.dt     = dt;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= c1_next;
            c2_reg  <= c1_reg;
            sqx_reg <= 64'(pfi_pkg::absval(c1_reg.d_x)) * 64'(pfi_pkg::absval(c1_reg.d_x));
            sqy_reg <= 64'(pfi_pkg::absval(c1_reg.d_y)) * 64'(pfi_pkg::absval(c1_reg.d_y));
            sqz_reg <= 64'(pfi_pkg::absval(c1_reg.d_z)) * 64'(pfi_pkg::absval(c1_reg.d_z));
            c3_reg  <= c2_reg;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    for (genvar k = 0; k < pfi_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        carry_t      c_in;
        logic [63:0] n_in, r_in, trial;

        if (k == 0)
        begin : g_first
            assign c_in = c3_reg;
            assign n_in = sum_reg;
            assign r_in = 64'd0;
        end
        else
        begin : g_rest
            assign c_in = sq_c_reg[k-1];
            assign n_in = sq_n_reg[k-1];
            assign r_in = sq_r_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_c_reg[k] <= c_in;
                if (n_in >= trial)
                begin
                    sq_n_reg[k] <= n_in - trial;
                    sq_r_reg[k] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    sq_n_reg[k] <= n_in;
                    sq_r_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    assign root      = sq_r_reg[pfi_pkg::SQRT_STEPS-1][31:0];
    assign dist_sum  = {1'b0, root} + 33'(pfi_pkg::DIST_BIAS);
    assign dist_next = (dist_sum > 33'h07FFFFFFF) ? 32'h7FFFFFFF : dist_sum[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds_c_reg    <= sq_c_reg[pfi_pkg::SQRT_STEPS-1];
            ds_dist_reg <= dist_next;
            ds_hit_reg  <= dist_next < {1'b0, sq_c_reg[pfi_pkg::SQRT_STEPS-1].radius};
            ds_neg_reg  <= sq_c_reg[pfi_pkg::SQRT_STEPS-1].st[31];
            ds_qd_reg   <= {pfi_pkg::absval(sq_c_reg[pfi_pkg::SQRT_STEPS-1].st),
                            {(pfi_pkg::DIV_STEPS-32){1'b0}}};
        end
    end

    for (genvar k = 0; k < pfi_pkg::DIV_STEPS; k++)
    begin : g_div
        carry_t                        c_in;
        logic [31:0]                   dist_in, rem_in;
        logic [pfi_pkg::DIV_STEPS-1:0] qd_in;
        logic                          hit_in, neg_in, ge;
        logic [32:0]                   t;

        if (k == 0)
        begin : g_first
            assign c_in    = ds_c_reg;
            assign dist_in = ds_dist_reg;
            assign rem_in  = 32'd0;
            assign qd_in   = ds_qd_reg;
            assign hit_in  = ds_hit_reg;
            assign neg_in  = ds_neg_reg;
        end
        else
        begin : g_rest
            assign c_in    = dq_c_reg[k-1];
            assign dist_in = dq_dist_reg[k-1];
            assign rem_in  = dq_rem_reg[k-1];
            assign qd_in   = dq_qd_reg[k-1];
            assign hit_in  = dq_hit_reg[k-1];
            assign neg_in  = dq_neg_reg[k-1];
        end

        assign t  = {rem_in, qd_in[pfi_pkg::DIV_STEPS-1]};
        assign ge = t >= {1'b0, dist_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_c_reg[k]    <= c_in;
                dq_dist_reg[k] <= dist_in;
                dq_rem_reg[k]  <= ge ? 32'(t - {1'b0, dist_in}) : t[31:0];
                dq_qd_reg[k]   <= {qd_in[pfi_pkg::DIV_STEPS-2:0], ge};
                dq_hit_reg[k]  <= hit_in;
                dq_neg_reg[k]  <= neg_in;
            end
        end
    end

    assign qq = 64'(dq_qd_reg[pfi_pkg::DIV_STEPS-1]);
    assign sv = dq_neg_reg[pfi_pkg::DIV_STEPS-1] ? -$signed(qq) : $signed(qq);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg_c_reg   <= dq_c_reg[pfi_pkg::DIV_STEPS-1];
            sg_hit_reg <= dq_hit_reg[pfi_pkg::DIV_STEPS-1];
            sg_s_reg   <= pfi_pkg::sat32(sv);
        end
    end

    assign dt_s = $signed({11'd0, sg_c_reg.dt});

    always_comb
    begin
        ax_op = 32'sd0;
        ay_op = 32'sd0;
        az_op = 32'sd0;
        b_op  = 32'sd0;
        unique case (sg_c_reg.kind)
            pfi_pkg::KIND_GRAVITY:
            begin
                ay_op = sg_c_reg.st;
                b_op  = dt_s;
            end
            pfi_pkg::KIND_WIND:
            begin
                ax_op = sg_c_reg.dir_x;
                ay_op = sg_c_reg.dir_y;
                az_op = sg_c_reg.dir_z;
                b_op  = sg_c_reg.st;
            end
            pfi_pkg::KIND_ATTRACTOR:
            begin
                ax_op = sg_c_reg.d_x;
                ay_op = sg_c_reg.d_y;
                az_op = sg_c_reg.d_z;
                b_op  = sg_s_reg;
            end
            default:
            begin
                b_op = 32'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_kind_reg <= sg_c_reg.kind;
            m_hit_reg  <= sg_hit_reg;
            m_dt_reg   <= sg_c_reg.dt;
            mx_reg     <= pfi_pkg::qmul(ax_op, b_op);
            my_reg     <= pfi_pkg::qmul(ay_op, b_op);
            mz_reg     <= pfi_pkg::qmul(az_op, b_op);
        end
    end

    always_comb
    begin
        dv_next.x = 33'sd0;
        dv_next.y = 33'sd0;
        dv_next.z = 33'sd0;
        unique case (m_kind_reg)
            pfi_pkg::KIND_GRAVITY:
            begin
                dv_next.y = -33'(my_reg);
            end
            pfi_pkg::KIND_WIND:
            begin
                dv_next.x = 33'(pfi_pkg::qmul(mx_reg, $signed({11'd0, m_dt_reg})));
                dv_next.y = 33'(pfi_pkg::qmul(my_reg, $signed({11'd0, m_dt_reg})));
                dv_next.z = 33'(pfi_pkg::qmul(mz_reg, $signed({11'd0, m_dt_reg})));
            end
            pfi_pkg::KIND_ATTRACTOR:
            begin
                if (m_hit_reg)
                begin
                    dv_next.x = 33'(pfi_pkg::qmul(mx_reg, $signed({11'd0, m_dt_reg})));
                    dv_next.y = 33'(pfi_pkg::qmul(my_reg, $signed({11'd0, m_dt_reg})));
                    dv_next.z = 33'(pfi_pkg::qmul(mz_reg, $signed({11'd0, m_dt_reg})));
                end
            end
            default:
            begin
                dv_next.x = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= dv_next;
        end
    end

    assign dv = dv_reg;

endmodule

>>> rtl/particle_force_integrate.sv
// Top level of the particle force integrator: slot store, slot lanes and velocity/position pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | to block  | in_valid / in_ready  | func slot kind dt vec_a_* vec_b_* scalar_a/b
//  out     | from block| out_valid / out_ready| pos_* vel_* age_out alive
//
//  One transaction per cycle while the output is not stalled; an update passes through the
//  slot lanes (32-step square root, 48-step divide), then the accumulate, position and output registers.
//  A load transaction writes its slot at acceptance and yields no output.
//  Reset clears all slot kinds and empties the pipeline.
//  While an output waits unaccepted, the whole pipeline holds and in_ready is low.
module particle_force_integrate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic        [1:0]  slot,
    input  logic        [1:0]  kind,
    input  logic        [20:0] dt,
    input  logic signed [31:0] vec_a_x,
    input  logic signed [31:0] vec_a_y,
    input  logic signed [31:0] vec_a_z,
    input  logic signed [31:0] vec_b_x,
    input  logic signed [31:0] vec_b_y,
    input  logic signed [31:0] vec_b_z,
    input  logic signed [31:0] scalar_a,
    input  logic        [30:0] scalar_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] age_out,
    output logic               alive
);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] age;
        logic               alive;
        logic        [20:0] dt;
    } pdat_t;

    logic en, accept;

    pfi_pkg::kind_t kind_reg [pfi_pkg::FORCE_SLOTS];
    pfi_pkg::slot_t par_reg  [pfi_pkg::FORCE_SLOTS];
    pfi_pkg::slot_t par_next;
    pfi_pkg::dv_t   lane_dv  [pfi_pkg::FORCE_SLOTS];

    pdat_t              dl_next;
    logic signed [31:0] age_next;
    pdat_t              dl_reg    [pfi_pkg::LANE_LAT];
    logic               dl_vld_reg[pfi_pkg::LANE_LAT];

    pdat_t        acc_reg    [pfi_pkg::FORCE_SLOTS];
    logic         acc_vld_reg[pfi_pkg::FORCE_SLOTS];
    pfi_pkg::dv_t acc_dv_reg [pfi_pkg::FORCE_SLOTS][pfi_pkg::FORCE_SLOTS];

    pdat_t              pm_reg;
    logic               pm_vld_reg;
    logic signed [31:0] prx_reg, pry_reg, prz_reg;

    pdat_t out_next, out_reg;
    logic  out_vld_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    assign par_next.strength = scalar_a;
    assign par_next.dir_x    = vec_b_x;
    assign par_next.dir_y    = vec_b_y;
    assign par_next.dir_z    = vec_b_z;
    assign par_next.pos_x    = vec_a_x;
    assign par_next.pos_y    = vec_a_y;
    assign par_next.pos_z    = vec_a_z;
    assign par_next.radius   = scalar_b;

    for (genvar i = 0; i < pfi_pkg::FORCE_SLOTS; i++)
    begin : g_slot
        logic wr;
        assign wr = accept && (func == pfi_pkg::FUNC_LOAD) && (32'(slot) == i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                kind_reg[i] <= pfi_pkg::KIND_NONE;
            end
            else if (wr)
            begin
                kind_reg[i] <= pfi_pkg::kind_t'(kind);
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr)
            begin
                par_reg[i] <= par_next;
            end
        end

        pfi_lane u_lane (
            .clk   (clk),
            .en    (en),
            .kind  (kind_reg[i]),
            .cfg   (par_reg[i]),
            .pos_x (vec_a_x),
            .pos_y (vec_a_y),
            .pos_z (vec_a_z),
            .dt    (dt),
            .dv    (lane_dv[i])
        );
    end

    assign age_next      = pfi_pkg::qadd(scalar_a, $signed({11'd0, dt}));
    assign dl_next.pos_x = vec_a_x;
    assign dl_next.pos_y = vec_a_y;
    assign dl_next.pos_z = vec_a_z;
    assign dl_next.vel_x = vec_b_x;
    assign dl_next.vel_y = vec_b_y;
    assign dl_next.vel_z = vec_b_z;
    assign dl_next.age   = age_next;
    assign dl_next.alive = age_next < $signed({1'b0, scalar_b});
    assign dl_next.dt    = dt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pfi_pkg::LANE_LAT; i++)
            begin
                dl_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dl_vld_reg[0] <= accept && (func == pfi_pkg::FUNC_UPDATE);
            for (int i = 1; i < pfi_pkg::LANE_LAT; i++)
            begin
                dl_vld_reg[i] <= dl_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= dl_next;
            for (int i = 1; i < pfi_pkg::LANE_LAT; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < pfi_pkg::FORCE_SLOTS; k++)
    begin : g_acc
        pdat_t        d_in, d_out;
        logic         v_in;
        pfi_pkg::dv_t dv_in [pfi_pkg::FORCE_SLOTS];

        if (k == 0)
        begin : g_first
            assign d_in  = dl_reg[pfi_pkg::LANE_LAT-1];
            assign v_in  = dl_vld_reg[pfi_pkg::LANE_LAT-1];
            assign dv_in = lane_dv;
        end
        else
        begin : g_rest
            assign d_in  = acc_reg[k-1];
            assign v_in  = acc_vld_reg[k-1];
            assign dv_in = acc_dv_reg[k-1];
        end

        always_comb
        begin
            d_out = d_in;
            if (d_in.alive)
            begin
                d_out.vel_x = pfi_pkg::addv(d_in.vel_x, dv_in[k].x);
                d_out.vel_y = pfi_pkg::addv(d_in.vel_y, dv_in[k].y);
                d_out.vel_z = pfi_pkg::addv(d_in.vel_z, dv_in[k].z);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                acc_vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k]    <= d_out;
                acc_dv_reg[k] <= dv_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pm_vld_reg  <= acc_vld_reg[pfi_pkg::FORCE_SLOTS-1];
            out_vld_reg <= pm_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg  <= acc_reg[pfi_pkg::FORCE_SLOTS-1];
            prx_reg <= pfi_pkg::qmul(acc_reg[pfi_pkg::FORCE_SLOTS-1].vel_x,
                                     $signed({11'd0, acc_reg[pfi_pkg::FORCE_SLOTS-1].dt}));
            pry_reg <= pfi_pkg::qmul(acc_reg[pfi_pkg::FORCE_SLOTS-1].vel_y,
                                     $signed({11'd0, acc_reg[pfi_pkg::FORCE_SLOTS-1].dt}));
            prz_reg <= pfi_pkg::qmul(acc_reg[pfi_pkg::FORCE_SLOTS-1].vel_z,
                                     $signed({11'd0, acc_reg[pfi_pkg::FORCE_SLOTS-1].dt}));
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next = pm_reg;
        if (pm_reg.alive)
        begin
            out_next.pos_x = pfi_pkg::qadd(pm_reg.pos_x, prx_reg);
            out_next.pos_y = pfi_pkg::qadd(pm_reg.pos_y, pry_reg);
            out_next.pos_z = pfi_pkg::qadd(pm_reg.pos_z, prz_reg);
        end
    end

    assign out_valid = out_vld_reg;
    assign pos_x     = out_reg.pos_x;
    assign pos_y     = out_reg.pos_y;
    assign pos_z     = out_reg.pos_z;
    assign vel_x     = out_reg.vel_x;
    assign vel_y     = out_reg.vel_y;
    assign vel_z     = out_reg.vel_z;
    assign age_out   = out_reg.age;
    assign alive     = out_reg.alive;

endmodule

>>> rtl/pfi_checker.sv
// Port-level checks for the particle force integrator, bound to the top level.
module pfi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] age_out,
    input logic               alive
);

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_empty_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(age_out) && $stable(alive))
        else $error("output payload changed while stalled");

endmodule

bind particle_force_integrate pfi_checker u_pfi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .age_out   (age_out),
    .alive     (alive)
);
